@@ src/cbor_dec_pkg.sv @@
// Shared types, codes and helpers for the CBOR to native layout decoder.
package cbor_dec_pkg;

  localparam int NEST_MAX_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int POS_BITS       = 16;
  localparam int NSLOT          = 6;
  localparam int SLOT_STATUS    = NSLOT - 1;

  localparam logic [4:0] AI_ONE_BYTE = 5'd24;
  localparam logic [4:0] AI_RSVD_LO  = 5'd28;
  localparam logic [4:0] AI_INDEF    = 5'd31;
  localparam logic [7:0] FILL_BYTE   = 8'hff;
  localparam logic [7:0] SIMPLE_FALSE = 8'd20;
  localparam logic [7:0] SIMPLE_TRUE  = 8'd21;
  localparam logic [7:0] SIMPLE_NULL  = 8'd22;

  localparam logic [2:0] MAJ_UINT  = 3'd0;
  localparam logic [2:0] MAJ_NINT  = 3'd1;
  localparam logic [2:0] MAJ_BSTR  = 3'd2;
  localparam logic [2:0] MAJ_TSTR  = 3'd3;
  localparam logic [2:0] MAJ_ARRAY = 3'd4;
  localparam logic [2:0] MAJ_MAP   = 3'd5;
  localparam logic [2:0] MAJ_TAG   = 3'd6;
  localparam logic [2:0] MAJ_FLOAT = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DEEP    = 3'd4;
  localparam logic [2:0] ST_TAG     = 3'd5;

  localparam logic REG_MSG_LEN = 1'b0;
  localparam logic REG_OUT_LEN = 1'b1;

  typedef struct packed {
    logic [NSLOT-1:0]                mask;
    logic [NSLOT-1:0][7:0]           bytes;
    logic [NSLOT-1:0][POS_BITS-1:0]  idx;
    logic [2:0]                      st;
  } bundle_t;

  function automatic logic [7:0] simple_map(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == SIMPLE_FALSE || v == SIMPLE_NULL) r = 8'd0;
    else if (v == SIMPLE_TRUE) r = 8'd1;
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] rem_of(input logic [POS_BITS-1:0] lim,
                                                 input logic [POS_BITS-1:0] pos);
    return (lim > pos) ? lim - pos : '0;
  endfunction

endpackage

@@ src/cbor_dec_if.sv @@
// Input and output channel interfaces of the decoder.
interface cbor_dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_start;
  modport source (output valid, in_byte, msg_start, input ready);
  modport sink (input valid, in_byte, msg_start, output ready);
endinterface

interface cbor_dec_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] out_index;
  logic        is_status;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, out_byte, out_index, is_status, status, last, input ready);
  modport sink (input valid, out_byte, out_index, is_status, status, last, output ready);
endinterface

@@ src/cbor_dec_outq.sv @@
// Result slot buffer: holds the results of one byte and drains them in order.
module cbor_dec_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cbor_dec_pkg::bundle_t  bun,
  output logic                   can_load,
  cbor_dec_out_if.source         out_ch
);

  localparam int N = cbor_dec_pkg::NSLOT;

  logic [N-1:0]                                   mask;
  logic [N-1:0][7:0]                              bytes;
  logic [N-1:0][cbor_dec_pkg::POS_BITS-1:0]       idx;
  logic [2:0]                                     st;
  logic [N-1:0]                                   sel;
  logic                                           found;
  logic                                           fire;
  logic                                           last;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (mask[i] && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  assign last     = (mask & ~sel) == '0;
  assign fire     = out_ch.valid && out_ch.ready;
  assign can_load = (mask == '0) || (last && out_ch.ready);

  always_comb begin
    out_ch.out_byte  = '0;
    out_ch.out_index = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) begin
        out_ch.out_byte  = bytes[i];
        out_ch.out_index = idx[i];
      end
    end
  end

  assign out_ch.valid     = |mask;
  assign out_ch.is_status = sel[cbor_dec_pkg::SLOT_STATUS];
  assign out_ch.status    = sel[cbor_dec_pkg::SLOT_STATUS] ? st : cbor_dec_pkg::ST_OK;
  assign out_ch.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= bun.mask;
    end else if (fire) begin
      mask <= mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= bun.bytes;
      idx   <= bun.idx;
      st    <= bun.st;
    end
  end

endmodule

@@ src/cbor_to_native_decoder_core.sv @@
// CBOR message to packed little-endian native layout decoder, top level.
// Usage: message bytes enter on in_ch, one per transaction, msg_start set on
// the first byte of each message. Each byte yields zero to six results on
// out_ch: packed output bytes with their buffer position, then one status
// result (is_status) once decoding ends; last marks the final result of a
// byte. Bytes after the end give no results until the next msg_start.
// message_length and output_length must be written through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce this.
// Timing: the first result of a byte is on out_ch the cycle after it is
// accepted. The result buffer drains one result per cycle while the
// receiver takes them; in_ch.ready is high when the buffer is
// empty or its final result is being taken in the same cycle. Single-result
// bytes stream at one per cycle when the receiver does not stall.
// When the receiver stalls, results hold and in_ch stalls behind them.
// Reset (rst, synchronous) empties the result buffer, clears decode state
// and sets message_length to 1 and output_length to 0.
module cbor_to_native_decoder_core #(
  parameter int NEST_MAX   = cbor_dec_pkg::NEST_MAX_DEF,
  parameter int COUNT_BITS = cbor_dec_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  cbor_dec_in_if.sink          in_ch,
  cbor_dec_out_if.source       out_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int PW = cbor_dec_pkg::POS_BITS;
  localparam int LW = $clog2(NEST_MAX + 1);
  localparam int IW = (NEST_MAX > 1) ? $clog2(NEST_MAX) : 1;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_BODY} phase_t;

  // decode state
  logic [COUNT_BITS-1:0] count_stack [NEST_MAX];
  logic [NEST_MAX-1:0]   open_ended_stack;
  logic [NEST_MAX-1:0]   one_left;
  logic [LW-1:0]         nest_level;
  phase_t                header_phase;
  logic [2:0]            major_kind;
  logic [63:0]           argument_acc;
  logic [3:0]            argument_left;
  logic [3:0]            arg_size;
  logic                  neg_fill;
  logic [PW-1:0]         string_left;
  logic [PW-1:0]         message_pos;
  logic [PW-1:0]         output_pos;
  logic                  finished;
  logic [PW-1:0]         message_length;
  logic [PW-1:0]         output_length;

  // current view after msg_start clear
  logic [NEST_MAX-1:0]   c_open;
  logic [LW-1:0]         c_lvl;
  phase_t                c_ph;
  logic [3:0]            c_al, c_as;
  logic [PW-1:0]         c_mp, c_op, c_sl;
  logic                  c_fin;
  logic [63:0]           c_acc;
  logic [2:0]            c_mk;

  // next values
  logic [LW-1:0]         nest_level_next;
  phase_t                header_phase_next;
  logic [2:0]            major_kind_next;
  logic [63:0]           argument_acc_next;
  logic [3:0]            argument_left_next, arg_size_next;
  logic                  neg_fill_next;
  logic [PW-1:0]         string_left_next, message_pos_next, output_pos_next;
  logic                  finished_next;
  logic [NEST_MAX-1:0]   open_ended_stack_next;

  logic [7:0]            b;
  logic [4:0]            ai;
  logic [2:0]            major;
  logic                  indef;
  logic [3:0]            sz;
  logic [PW-1:0]         rem_m, rem_o, room;
  logic                  do_fin;
  logic [2:0]            fin_st;
  logic                  tv_en;
  logic [63:0]           tv_v;
  logic                  ol_en, ol_open;
  logic [COUNT_BITS-1:0] ol_cnt;
  logic                  do_cmp;
  logic [LW-1:0]         cs, blk;
  logic [LW-1:0]         dec_lvl;
  logic                  wr_en, wr_open;
  logic [IW-1:0]         wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [PW:0]           np;
  logic [4:0]            w;
  logic [64:0]           vx;
  logic                  sat;
  cbor_dec_pkg::bundle_t bun;
  logic                  can_load;
  logic                  in_fire;

  assign in_ch.ready = can_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign b     = in_ch.in_byte;
  assign ai    = b[4:0];
  assign major = b[7:5];
  assign indef = (ai == cbor_dec_pkg::AI_INDEF);

  always_comb begin
    unique case (ai[1:0])
      2'd0:    sz = 4'd1;
      2'd1:    sz = 4'd2;
      2'd2:    sz = 4'd4;
      default: sz = 4'd8;
    endcase
    if (ai < cbor_dec_pkg::AI_ONE_BYTE || ai >= cbor_dec_pkg::AI_RSVD_LO) sz = 4'd0;
  end

  always_comb begin
    if (in_ch.msg_start) begin
      c_open = '0; c_lvl = '0; c_ph = PH_HEAD; c_mk = '0; c_acc = '0;
      c_al = '0; c_as = '0; c_sl = '0; c_mp = '0; c_op = '0; c_fin = 1'b0;
    end else begin
      c_open = open_ended_stack; c_lvl = nest_level; c_ph = header_phase;
      c_mk = major_kind; c_acc = argument_acc; c_al = argument_left;
      c_as = arg_size; c_sl = string_left; c_mp = message_pos;
      c_op = output_pos; c_fin = finished;
    end
  end

  always_comb begin
    nest_level_next    = c_lvl;
    header_phase_next  = c_ph;
    major_kind_next    = c_mk;
    argument_acc_next  = c_acc;
    argument_left_next = c_al;
    arg_size_next      = c_as;
    neg_fill_next      = neg_fill;
    string_left_next   = c_sl;
    message_pos_next   = c_mp;
    output_pos_next    = c_op;
    do_fin   = 1'b0;
    fin_st   = cbor_dec_pkg::ST_OK;
    tv_en    = 1'b0;
    tv_v     = '0;
    ol_en    = 1'b0;
    ol_open  = 1'b0;
    ol_cnt   = '0;
    do_cmp   = 1'b0;
    cs       = c_lvl;
    blk      = '0;
    dec_lvl  = '0;
    wr_en    = 1'b0;
    wr_open  = 1'b0;
    wr_idx   = '0;
    wr_cnt   = '0;
    np       = '0;
    w        = '0;
    vx       = '0;
    sat      = 1'b0;
    room     = '0;
    bun      = '0;
    rem_m    = cbor_dec_pkg::rem_of(message_length, c_mp);
    rem_o    = cbor_dec_pkg::rem_of(output_length, c_op);

    if (!c_fin) begin
      unique case (c_ph)
        PH_HEAD: begin
          if (c_mp < message_length && c_op < output_length) begin
            if (ai >= cbor_dec_pkg::AI_RSVD_LO && !indef) begin
              do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_ILLEGAL;
            end else if (!indef && ({1'b0, 12'd0, sz} + 17'd1 > {1'b0, rem_m})) begin
              do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_ILLEGAL;
            end else if (!indef && ({12'd0, sz} > rem_o)) begin
              do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_UNDER;
            end else begin
              message_pos_next   = c_mp + 1'b1;
              major_kind_next    = major;
              arg_size_next      = sz;
              argument_left_next = sz;
              argument_acc_next  = '0;
              if (major == cbor_dec_pkg::MAJ_TAG) begin
                do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_TAG;
              end else if (sz != 4'd0) begin
                header_phase_next = PH_ARG;
              end else if (indef) begin
                if (major <= cbor_dec_pkg::MAJ_NINT) begin
                  do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_ILLEGAL;
                end else if (major <= cbor_dec_pkg::MAJ_MAP) begin
                  ol_en = 1'b1; ol_open = 1'b1;
                end else if (c_lvl != '0 && c_open[IW'(c_lvl - 1'b1)]) begin
                  // break closes the open-ended level, then counts as its item
                  cs = c_lvl - 1'b1; do_cmp = 1'b1;
                end else begin
                  do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_ILLEGAL;
                end
              end else begin
                case (major)
                  cbor_dec_pkg::MAJ_UINT: begin
                    bun.mask[0] = 1'b1; bun.bytes[0] = {3'd0, ai};
                  end
                  cbor_dec_pkg::MAJ_NINT: begin
                    bun.mask[0] = 1'b1; bun.bytes[0] = ~{3'd0, ai};
                  end
                  cbor_dec_pkg::MAJ_FLOAT: begin
                    bun.mask[0] = 1'b1; bun.bytes[0] = cbor_dec_pkg::simple_map({3'd0, ai});
                  end
                  default: begin
                    tv_en = 1'b1; tv_v = {59'd0, ai};
                  end
                endcase
                if (bun.mask[0]) begin
                  bun.idx[0] = c_op; output_pos_next = c_op + 1'b1; do_cmp = 1'b1;
                end
              end
            end
          end
        end
        PH_ARG: begin
          argument_acc_next = {c_acc[55:0], b};
          bun.idx[0] = c_op + PW'(c_al) - 1'b1;
          bun.bytes[0] = b;
          if (c_mk == cbor_dec_pkg::MAJ_UINT) begin
            bun.mask[0] = 1'b1;
          end else if (c_mk == cbor_dec_pkg::MAJ_FLOAT) begin
            bun.mask[0] = 1'b1;
            if (c_as == 4'd1) bun.bytes[0] = cbor_dec_pkg::simple_map(b);
          end else if (c_mk == cbor_dec_pkg::MAJ_NINT) begin
            bun.mask[0] = 1'b1; bun.bytes[0] = ~b;
            // sign fill to double width, bytes past output_length dropped
            if (c_al == c_as && b[7] && c_as < 4'd8) begin
              for (int j = 0; j < 4; j++) begin
                if (j < 32'(c_as) &&
                    ({1'b0, c_op} + (PW+1)'(c_as) + (PW+1)'(j) < {1'b0, output_length})) begin
                  bun.mask[j+1]  = 1'b1;
                  bun.bytes[j+1] = cbor_dec_pkg::FILL_BYTE;
                  bun.idx[j+1]   = c_op + PW'(c_as) + PW'(j);
                end
              end
            end
          end
          if (c_al == c_as) neg_fill_next = b[7];
          message_pos_next   = c_mp + 1'b1;
          argument_left_next = c_al - 1'b1;
          if (argument_left_next == 4'd0) begin
            header_phase_next = PH_HEAD;
            if (c_mk == cbor_dec_pkg::MAJ_UINT || c_mk == cbor_dec_pkg::MAJ_FLOAT) begin
              output_pos_next = c_op + PW'(c_as); do_cmp = 1'b1;
            end else if (c_mk == cbor_dec_pkg::MAJ_NINT) begin
              w = (c_as < 4'd8 && neg_fill_next) ? {c_as, 1'b0} : {1'b0, c_as};
              np = {1'b0, c_op} + (PW+1)'(w);
              output_pos_next = (np > {1'b0, output_length}) ? output_length : np[PW-1:0];
              do_cmp = 1'b1;
            end else begin
              tv_en = 1'b1; tv_v = argument_acc_next;
            end
          end
        end
        default: begin
          bun.mask[0] = 1'b1; bun.bytes[0] = b; bun.idx[0] = c_op;
          output_pos_next  = c_op + 1'b1;
          message_pos_next = c_mp + 1'b1;
          string_left_next = c_sl - 1'b1;
          if (string_left_next == '0) begin
            header_phase_next = PH_HEAD; do_cmp = 1'b1;
          end
        end
      endcase

      if (tv_en) begin
        header_phase_next = PH_HEAD;
        if (major_kind_next == cbor_dec_pkg::MAJ_BSTR ||
            major_kind_next == cbor_dec_pkg::MAJ_TSTR) begin
          room = cbor_dec_pkg::rem_of(output_length, output_pos_next);
          if (cbor_dec_pkg::rem_of(message_length, message_pos_next) < room)
            room = cbor_dec_pkg::rem_of(message_length, message_pos_next);
          if (tv_v > {48'd0, room}) begin
            do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_ILLEGAL;
          end else if (tv_v == '0) begin
            do_cmp = 1'b1;
          end else begin
            string_left_next = tv_v[PW-1:0]; header_phase_next = PH_BODY;
          end
        end else if (tv_v == '0) begin
          do_cmp = 1'b1;
        end else begin
          vx = {1'b0, tv_v};
          ol_en = 1'b1;
          if (major_kind_next == cbor_dec_pkg::MAJ_MAP) begin
            sat = |(vx >> (COUNT_BITS - 1));
            ol_cnt = sat ? {COUNT_BITS{1'b1}} : vx[COUNT_BITS-1:0] << 1;
          end else begin
            sat = |(vx >> COUNT_BITS);
            ol_cnt = sat ? {COUNT_BITS{1'b1}} : vx[COUNT_BITS-1:0];
          end
        end
      end

      if (ol_en) begin
        if (c_lvl >= LW'(NEST_MAX)) begin
          do_fin = 1'b1; fin_st = cbor_dec_pkg::ST_DEEP;
        end else begin
          wr_en = 1'b1; wr_idx = c_lvl[IW-1:0]; wr_cnt = ol_cnt; wr_open = ol_open;
          nest_level_next = c_lvl + 1'b1;
        end
      end

      if (do_cmp) begin
        // pop the top run of definite levels with one item left, then count one item
        // in the level that remains if it is definite
        for (int i = 0; i < NEST_MAX; i++) begin
          if (LW'(i) < cs && !one_left[i]) blk = LW'(i + 1);
        end
        nest_level_next = blk;
        if (blk != '0) begin
          dec_lvl = blk - 1'b1;
          if (!c_open[dec_lvl[IW-1:0]]) begin
            wr_en = 1'b1; wr_idx = dec_lvl[IW-1:0];
            wr_cnt = count_stack[dec_lvl[IW-1:0]] - 1'b1; wr_open = 1'b0;
          end
        end
      end

      if (!do_fin && header_phase_next == PH_HEAD &&
          !(message_pos_next < message_length && output_pos_next < output_length)) begin
        do_fin = 1'b1;
        if (message_pos_next < message_length) fin_st = cbor_dec_pkg::ST_OVER;
        else if (nest_level_next != '0) fin_st = cbor_dec_pkg::ST_ILLEGAL;
        else if (output_pos_next < output_length) fin_st = cbor_dec_pkg::ST_UNDER;
        else fin_st = cbor_dec_pkg::ST_OK;
      end
    end

    finished_next = c_fin || do_fin;
    bun.mask[cbor_dec_pkg::SLOT_STATUS]  = do_fin;
    bun.bytes[cbor_dec_pkg::SLOT_STATUS] = '0;
    bun.idx[cbor_dec_pkg::SLOT_STATUS]   = output_pos_next;
    bun.st = fin_st;
  end

  always_comb begin
    open_ended_stack_next = c_open;
    if (wr_en) open_ended_stack_next[wr_idx] = wr_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_ended_stack <= '0;
      one_left         <= '0;
      nest_level       <= '0;
      header_phase     <= PH_HEAD;
      major_kind       <= '0;
      argument_acc     <= '0;
      argument_left    <= '0;
      arg_size         <= '0;
      neg_fill         <= 1'b0;
      string_left      <= '0;
      message_pos      <= '0;
      output_pos       <= '0;
      finished         <= 1'b0;
    end else if (in_fire) begin
      open_ended_stack <= open_ended_stack_next;
      if (wr_en) one_left[wr_idx] <= !wr_open && (wr_cnt == COUNT_BITS'(1));
      nest_level    <= nest_level_next;
      header_phase  <= header_phase_next;
      major_kind    <= major_kind_next;
      argument_acc  <= argument_acc_next;
      argument_left <= argument_left_next;
      arg_size      <= arg_size_next;
      neg_fill      <= neg_fill_next;
      string_left   <= string_left_next;
      message_pos   <= message_pos_next;
      output_pos    <= output_pos_next;
      finished      <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) count_stack[wr_idx] <= wr_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= 16'd1;
      output_length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbor_dec_pkg::REG_MSG_LEN: message_length <= cfg_data;
        cbor_dec_pkg::REG_OUT_LEN: output_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  cbor_dec_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (in_fire),
    .bun      (bun),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid) else $error("input stalled with no result pending");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    nest_level <= LW'(NEST_MAX)) else $error("nest level beyond stack depth");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_status |-> out_ch.last) else $error("status not last");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && finished && !in_ch.msg_start |=> !out_ch.valid)
    else $error("result after end of decoding");

endmodule
